// ----- rtl/r3sat_pkg.sv -----
// Shared types, constants and helpers for the random 3-SAT clause generator.
package r3sat_pkg;

  // Generator arithmetic
  localparam logic [63:0] GEN_MUL    = 64'd9395819399113;
  localparam logic [31:0] GEN_MUL_LO = GEN_MUL[31:0];
  localparam logic [31:0] GEN_MUL_HI = GEN_MUL[63:32];
  localparam logic [63:0] GEN_SUB    = 64'd49458174917981;
  localparam logic [63:0] GEN_OUTX   = 64'd135891753891;
  localparam int          GEN_SHIFT  = 17;
  localparam logic [63:0] SEED_RESET = 64'd6789175398151;

  // Field widths
  localparam int VAR_W     = 7;
  localparam int CNT_W     = 10;
  localparam int IDX_W     = 9;
  localparam int LIT_W     = 8;
  localparam int STATE_W   = 64;
  localparam int CFG_IDX_W = 2;

  // Limits
  localparam logic [VAR_W-1:0] MAX_VARS    = VAR_W'(64);
  localparam logic [CNT_W-1:0] MAX_CLAUSES = CNT_W'(512);
  localparam logic [VAR_W-1:0] VAR_RESET   = VAR_W'(64);
  localparam logic [CNT_W-1:0] CNT_RESET   = CNT_W'(512);

  // Remainder unit: bits folded in per cycle and cycles per draw
  localparam int MOD_STEP_BITS = 8;
  localparam int MOD_CYCLES    = STATE_W / MOD_STEP_BITS;
  localparam int MOD_CNT_W     = $clog2(MOD_CYCLES);

  localparam int NUM_LITS  = 3;
  localparam int LIT_SEL_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAUSE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED         = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_MOD,
    ST_LIT,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LO_LO,
    MUL_HI_LO,
    MUL_LO_HI
  } mul_op_t;

  typedef struct packed {
    logic                 start;
    mul_op_t              mul_op;
    logic                 mix;
    logic                 mod_step;
    logic                 store_lit;
    logic [LIT_SEL_W-1:0] lit_sel;
    logic                 load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/r3sat_ctrl.sv -----
// Sequencer for the clause generator: steps three draws, each multiply, mix, reduce, store.
module r3sat_ctrl
  import r3sat_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t          state, state_next;
  logic [MOD_CNT_W-1:0] mod_cnt, mod_cnt_next;
  logic [LIT_SEL_W-1:0] lit_sel, lit_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mod_cnt <= '0;
      lit_sel <= '0;
    end else begin
      state   <= state_next;
      mod_cnt <= mod_cnt_next;
      lit_sel <= lit_sel_next;
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    mod_cnt_next = mod_cnt;
    lit_sel_next = lit_sel;
    unique case (state)
      ST_IDLE: begin
        lit_sel_next = '0;
        if (in_valid) begin
          state_next = ST_MUL0;
        end
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MIX;
      ST_MIX: begin
        mod_cnt_next = '0;
        state_next   = ST_MOD;
      end
      ST_MOD: begin
        mod_cnt_next = mod_cnt + MOD_CNT_W'(1);
        if (mod_cnt == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          state_next = ST_LIT;
        end
      end
      ST_LIT: begin
        if (lit_sel == LIT_SEL_W'(NUM_LITS - 1)) begin
          state_next = ST_OUT;
        end else begin
          lit_sel_next = lit_sel + LIT_SEL_W'(1);
          state_next   = ST_MUL0;
        end
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.start     = 1'b0;
    cmd.mul_op    = MUL_NONE;
    cmd.mix       = 1'b0;
    cmd.mod_step  = 1'b0;
    cmd.store_lit = 1'b0;
    cmd.lit_sel   = lit_sel;
    cmd.load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_MUL0: cmd.mul_op    = MUL_LO_LO;
      ST_MUL1: cmd.mul_op    = MUL_HI_LO;
      ST_MUL2: cmd.mul_op    = MUL_LO_HI;
      ST_MIX:  cmd.mix       = 1'b1;
      ST_MOD:  cmd.mod_step  = 1'b1;
      ST_LIT:  cmd.store_lit = 1'b1;
      ST_OUT:  cmd.load_out  = !status.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- rtl/r3sat_dp.sv -----
// Datapath: generator state, shared 32x32 multiplier, remainder unit, clause counter, output stage.
module r3sat_dp
  import r3sat_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  logic                    reseed,
  input  logic [VAR_W-1:0]        n_eff,
  input  logic [CNT_W-1:0]        cnt_eff,
  input  logic [STATE_W-1:0]      seed,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [LIT_W-1:0] lit_a,
  output logic signed [LIT_W-1:0] lit_b,
  output logic signed [LIT_W-1:0] lit_c,
  output logic [IDX_W-1:0]        clause_index,
  output logic                    last_clause
);

  logic [STATE_W-1:0] gen_state;
  logic [STATE_W-1:0] acc;
  logic [STATE_W-1:0] draw;
  logic [LIT_W-1:0]   rem;
  logic [IDX_W-1:0]   clause_counter;
  logic [IDX_W-1:0]   cur_idx;
  logic               cur_last;
  logic [LIT_W-1:0]   lit_work [NUM_LITS];

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_HI_LO: begin
        mul_a = gen_state[63:32];
        mul_b = GEN_MUL_LO;
      end
      MUL_LO_HI: begin
        mul_a = gen_state[31:0];
        mul_b = GEN_MUL_HI;
      end
      default: begin
        mul_a = gen_state[31:0];
        mul_b = GEN_MUL_LO;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Subtract, rotate by low six bits, fold in the shifted copy
  logic [STATE_W-1:0]   sub_v;
  logic [2*STATE_W-1:0] rot_dbl;
  logic [STATE_W-1:0]   rot_v;
  logic [STATE_W-1:0]   mix_v;

  assign sub_v   = acc - GEN_SUB;
  assign rot_dbl = {sub_v, sub_v} >> sub_v[5:0];
  assign rot_v   = rot_dbl[STATE_W-1:0];
  assign mix_v   = rot_v ^ (rot_v >> GEN_SHIFT);

  // Restoring remainder, several bits per cycle, MSB first
  logic [LIT_W-1:0] divisor;
  logic [LIT_W-1:0] rem_next;

  assign divisor = {n_eff, 1'b0};

  always_comb begin
    logic [LIT_W-1:0] r;
    r = rem;
    for (int i = 0; i < MOD_STEP_BITS; i++) begin
      r = {r[LIT_W-2:0], draw[STATE_W-1-i]};
      if (r >= divisor) begin
        r = r - divisor;
      end
    end
    rem_next = r;
  end

  // Literal mapping: low half -> +1..n, high half -> -n..-1
  logic [LIT_W-1:0] lit_v;
  assign lit_v = (rem < {1'b0, n_eff}) ? rem + LIT_W'(1) : rem - divisor;

  // Clause position at accept
  logic [IDX_W-1:0] idx_base;
  logic [IDX_W-1:0] idx_v;
  logic [CNT_W-1:0] idx_inc;

  assign idx_base = reseed ? '0 : clause_counter;
  assign idx_v    = ({1'b0, idx_base} >= cnt_eff) ? '0 : idx_base;
  assign idx_inc  = {1'b0, idx_v} + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state      <= SEED_RESET;
      clause_counter <= '0;
    end else begin
      if (cmd.start) begin
        if (reseed) begin
          gen_state <= seed;
        end
        clause_counter <= (idx_inc >= cnt_eff) ? '0 : idx_inc[IDX_W-1:0];
      end
      if (cmd.mix) begin
        gen_state <= mix_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_idx  <= idx_v;
      cur_last <= (idx_inc == cnt_eff);
    end
    unique case (cmd.mul_op)
      MUL_LO_LO: acc <= mul_p;
      MUL_HI_LO,
      MUL_LO_HI: acc[63:32] <= acc[63:32] + mul_p[31:0];
      default: ;
    endcase
    if (cmd.mix) begin
      draw <= mix_v ^ GEN_OUTX;
      rem  <= '0;
    end
    if (cmd.mod_step) begin
      draw <= draw << MOD_STEP_BITS;
      rem  <= rem_next;
    end
    if (cmd.store_lit) begin
      lit_work[cmd.lit_sel] <= lit_v;
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      lit_a        <= lit_work[0];
      lit_b        <= lit_work[1];
      lit_c        <= lit_work[2];
      clause_index <= cur_idx;
      last_clause  <= cur_last;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

// ----- rtl/random_3sat_clause_generator_core.sv -----
// Top level of the random 3-SAT clause generator: config registers, sequencer, datapath.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    reseed
//   out      source     out_valid/out_ready  lit_a, lit_b, lit_c, clause_index, last_clause
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Per literal the sequencer steps through three beats on the shared 32x32 multiplier, a mix
// step, the remainder unit (8 bits per cycle over the 64-bit draw) and a store; after the
// third literal the clause is loaded into the output register.
// Input is accepted only while the sequencer is idle; a finished clause sits in the output
// register while the next beat is taken, and the next clause stalls until it drains.
// Sync active-high reset: config defaults, seed state, zero counter. cfg_ready always high.
module random_3sat_clause_generator_core
  import r3sat_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    reseed,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [LIT_W-1:0] lit_a,
  output logic signed [LIT_W-1:0] lit_b,
  output logic signed [LIT_W-1:0] lit_c,
  output logic [IDX_W-1:0]        clause_index,
  output logic                    last_clause,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [STATE_W-1:0]      cfg_data
);

  logic [VAR_W-1:0]   var_count;
  logic [CNT_W-1:0]   clause_count;
  logic [STATE_W-1:0] seed;

  assign cfg_ready = 1'b1;

  // Writes to unused indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      var_count    <= VAR_RESET;
      clause_count <= CNT_RESET;
      seed         <= SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VAR_COUNT:    var_count    <= cfg_data[VAR_W-1:0];
        CFG_CLAUSE_COUNT: clause_count <= cfg_data[CNT_W-1:0];
        CFG_SEED:         seed         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective counts: clamp to the limits, zero treated as one
  logic [VAR_W-1:0] n_eff;
  logic [CNT_W-1:0] cnt_eff;

  always_comb begin
    priority if (var_count > MAX_VARS) begin
      n_eff = MAX_VARS;
    end else if (var_count == '0) begin
      n_eff = VAR_W'(1);
    end else begin
      n_eff = var_count;
    end
    priority if (clause_count > MAX_CLAUSES) begin
      cnt_eff = MAX_CLAUSES;
    end else if (clause_count == '0) begin
      cnt_eff = CNT_W'(1);
    end else begin
      cnt_eff = clause_count;
    end
  end

  ctrl_cmd_t  cmd;
  dp_status_t status;

  r3sat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  r3sat_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .reseed       (reseed),
    .n_eff        (n_eff),
    .cnt_eff      (cnt_eff),
    .seed         (seed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .lit_a        (lit_a),
    .lit_b        (lit_b),
    .lit_c        (lit_c),
    .clause_index (clause_index),
    .last_clause  (last_clause)
  );

  // A literal is never zero
  a_lit_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lit_a != '0) && (lit_b != '0) && (lit_c != '0))
    else $error("zero literal in output beat");

  // Literals a and c stay within plus or minus n
  a_lit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(lit_a) <= $signed({1'b0, n_eff}))
               && ($signed(lit_a) >= -$signed({1'b0, n_eff}))
               && ($signed(lit_c) <= $signed({1'b0, n_eff}))
               && ($signed(lit_c) >= -$signed({1'b0, n_eff})))
    else $error("literal outside variable range");

  // Last flag agrees with the index and the clause count
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_clause == (({1'b0, clause_index} + CNT_W'(1)) == cnt_eff)))
    else $error("last_clause inconsistent with clause_index");

  // No new beat accepted while the sequencer is busy
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

endmodule
